>>> hdl/ibmh_pkg.sv
// shared constants, codes and types of the indexed binary min-heap
`default_nettype none
package ibmh_pkg;

   localparam int HEAP_DEPTH  = 1024;
   localparam int ELEMENT_IDS = 1024;
   localparam int KEY_BITS    = 32;

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int ELEM_W = $clog2(ELEMENT_IDS);
   localparam int CHILD_W = IDX_W + 2;

   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_EXTRACT = 2'd1;
   localparam logic [1:0] ACT_PEEK    = 2'd2;
   localparam logic [1:0] ACT_QUERY   = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;
   localparam logic [1:0] STS_DUP   = 2'd3;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [ELEM_W-1:0]   elem;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic insert_commit;
      logic extract_commit;
      logic rsp_load;
      logic rd_parent;
      logic rd_children;
      logic up_step;
      logic down_step;
      logic place;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       present;
      logic       count_zero;
      logic       count_one;
      logic       full;
      logic       at_root;
      logic       up_less;
      logic       no_child;
      logic       down_less;
      logic       clear_last;
      logic       rsp_free;
   } stat_type;

endpackage
`default_nettype wire

>>> hdl/ibmh_ctrl.sv
// controller state machine of the indexed binary min-heap
`default_nettype none
module ibmh_ctrl
   import ibmh_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DECIDE   = 3'd2;
   localparam logic [2:0] ST_UP_CHECK = 3'd3;
   localparam logic [2:0] ST_UP_CMP   = 3'd4;
   localparam logic [2:0] ST_DOWN_RD  = 3'd5;
   localparam logic [2:0] ST_DOWN_CMP = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = !((state_ff == ST_IDLE) && stat.rsp_free);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.accept = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.rsp_load = 1'b1;
            state_in = ST_IDLE;
            if (stat.action == ACT_INSERT && !stat.present && !stat.full) begin
               cmd.insert_commit = 1'b1;
               state_in = ST_UP_CHECK;
            end else if (stat.action == ACT_EXTRACT && !stat.count_zero) begin
               cmd.extract_commit = 1'b1;
               if (!stat.count_one) state_in = ST_DOWN_RD;
            end
         end
         ST_UP_CHECK: begin
            if (stat.at_root) begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_less) begin
               cmd.up_step = 1'b1;
               state_in = ST_UP_CHECK;
            end else begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DOWN_RD: begin
            if (stat.no_child) begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_children = 1'b1;
               state_in = ST_DOWN_CMP;
            end
         end
         ST_DOWN_CMP: begin
            if (stat.down_less) begin
               cmd.down_step = 1'b1;
               state_in = ST_DOWN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> hdl/ibmh_datapath.sv
// heap, slot map and presence memories with sift registers and result register
`default_nettype none
module ibmh_datapath
   import ibmh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [1:0]          req_action,
   input  wire logic [KEY_BITS-1:0] req_key,
   input  wire logic [ELEM_W-1:0]   req_element,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [KEY_BITS-1:0]      rsp_out_key,
   output logic [ELEM_W-1:0]        rsp_out_element,
   output logic                     rsp_is_present,
   output logic [IDX_W-1:0]         rsp_position,
   output logic [CNT_W-1:0]         rsp_count
);

   entry_type heap_mem [HEAP_DEPTH];
   logic [IDX_W-1:0] slot_mem [ELEMENT_IDS];
   logic presence_mem [ELEMENT_IDS];

   logic [1:0]          action_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [ELEM_W-1:0]   elem_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   entry_type           cur_ff, cur_in;
   logic [ELEM_W-1:0]   clr_idx_ff;
   entry_type           rd_a_ff, rd_b_ff;
   logic                pres_rd_ff;
   logic [IDX_W-1:0]    slot_rd_ff;
   logic                rsp_valid_ff;

   logic [IDX_W-1:0]   addr_a, addr_b, parent_idx, best_idx;
   logic [CHILD_W-1:0] l_idx, r_idx;
   logic               r_valid, pick_a;
   entry_type          best, heap_wd;
   logic               heap_we;
   logic               pres_we, pres_wd;
   logic [ELEM_W-1:0]  pres_wa;
   logic [CNT_W-1:0]   last_cnt;

   logic [1:0]          status_in;
   logic [KEY_BITS-1:0] okey_in;
   logic [ELEM_W-1:0]   oelem_in;
   logic                opres_in;
   logic [IDX_W-1:0]    opos_in;
   logic [CNT_W-1:0]    ocount_in;

   assign parent_idx = (idx_ff - 1'b1) >> 1;
   assign l_idx = {1'b0, idx_ff, 1'b1};
   assign r_idx = l_idx + 1'b1;
   assign r_valid = r_idx < CHILD_W'(count_ff);
   assign pick_a = !r_valid || (rd_a_ff.key < rd_b_ff.key);
   assign best = pick_a ? rd_a_ff : rd_b_ff;
   assign best_idx = pick_a ? l_idx[IDX_W-1:0] : r_idx[IDX_W-1:0];
   assign last_cnt = count_ff - 1'b1;

   always_comb begin
      addr_a = '0;
      addr_b = last_cnt[IDX_W-1:0];
      if (cmd.rd_parent) addr_a = parent_idx;
      if (cmd.rd_children) begin
         addr_a = l_idx[IDX_W-1:0];
         addr_b = r_idx[IDX_W-1:0];
      end
   end

   assign heap_we = cmd.up_step || cmd.down_step || cmd.place;
   assign heap_wd = cmd.up_step ? rd_a_ff : (cmd.down_step ? best : cur_ff);

   always_comb begin
      pres_we = cmd.clear_wr || cmd.insert_commit || cmd.extract_commit;
      pres_wa = clr_idx_ff;
      pres_wd = 1'b0;
      if (cmd.insert_commit) begin
         pres_wa = elem_ff;
         pres_wd = 1'b1;
      end else if (cmd.extract_commit) begin
         pres_wa = rd_a_ff.elem;
      end
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[idx_ff] <= heap_wd;
         slot_mem[heap_wd.elem] <= idx_ff;
      end
      rd_a_ff <= heap_mem[addr_a];
      rd_b_ff <= heap_mem[addr_b];
      slot_rd_ff <= slot_mem[req_element];
   end

   always_ff @(posedge clock) begin
      if (pres_we) presence_mem[pres_wa] <= pres_wd;
      pres_rd_ff <= presence_mem[req_element];
   end

   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      if (cmd.insert_commit) begin
         count_in = count_ff + 1'b1;
         idx_in = count_ff[IDX_W-1:0];
         cur_in.key = key_ff;
         cur_in.elem = elem_ff;
      end else if (cmd.extract_commit) begin
         count_in = last_cnt;
         idx_in = '0;
         cur_in = rd_b_ff;
      end else if (cmd.up_step) begin
         idx_in = parent_idx;
      end else if (cmd.down_step) begin
         idx_in = best_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clr_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.clear_wr) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      if (cmd.accept) begin
         action_ff <= req_action;
         key_ff <= req_key;
         elem_ff <= req_element;
      end
   end

   always_comb begin
      status_in = STS_OK;
      okey_in = '0;
      oelem_in = '0;
      opres_in = 1'b0;
      opos_in = '0;
      ocount_in = count_ff;
      case (action_ff)
         ACT_INSERT: begin
            okey_in = key_ff;
            oelem_in = elem_ff;
            if (pres_rd_ff) status_in = STS_DUP;
            else if (stat.full) status_in = STS_FULL;
            else ocount_in = count_ff + 1'b1;
         end
         ACT_EXTRACT, ACT_PEEK: begin
            if (stat.count_zero) begin
               status_in = STS_EMPTY;
            end else begin
               okey_in = rd_a_ff.key;
               oelem_in = rd_a_ff.elem;
               if (action_ff == ACT_EXTRACT) ocount_in = last_cnt;
            end
         end
         default: begin
            opres_in = pres_rd_ff;
            opos_in = pres_rd_ff ? slot_rd_ff : '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status <= status_in;
         rsp_out_key <= okey_in;
         rsp_out_element <= oelem_in;
         rsp_is_present <= opres_in;
         rsp_position <= opos_in;
         rsp_count <= ocount_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.action = action_ff;
      stat.present = pres_rd_ff;
      stat.count_zero = count_ff == '0;
      stat.count_one = count_ff == CNT_W'(1);
      stat.full = count_ff == CNT_W'(HEAP_DEPTH);
      stat.at_root = idx_ff == '0;
      stat.up_less = cur_ff.key < rd_a_ff.key;
      stat.no_child = l_idx >= CHILD_W'(count_ff);
      stat.down_less = best.key < cur_ff.key;
      stat.clear_last = clr_idx_ff == ELEM_W'(ELEMENT_IDS - 1);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

>>> hdl/indexed_binary_min_heap.sv
// Indexed binary min-heap of (key, element) pairs with per-element slot tracking.
// After reset a clearing pass empties the presence memory; no request beat is taken
// until it ends. One request is handled at a time. Every action gives its response
// beat from the result register, loaded in the decide state once the request
// beat is taken. Query, peek and rejected actions are then done, as is an extract
// that empties the heap; insert and other extracts go on sifting through the heap
// memory, each level a registered read and then a compare and move, before the
// next request beat is taken. The result register holds a stalled response beat
// while the sift goes on, but no new request beat is taken until that beat leaves.
`default_nettype none
module indexed_binary_min_heap
   import ibmh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_action,
   input  wire logic [KEY_BITS-1:0] req_key,
   input  wire logic [ELEM_W-1:0]   req_element,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [KEY_BITS-1:0]      rsp_out_key,
   output logic [ELEM_W-1:0]        rsp_out_element,
   output logic                     rsp_is_present,
   output logic [IDX_W-1:0]         rsp_position,
   output logic [CNT_W-1:0]         rsp_count
);

   cmd_type  cmd;
   stat_type stat;

   ibmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ibmh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_element (rsp_out_element),
      .rsp_is_present  (rsp_is_present),
      .rsp_position    (rsp_position),
      .rsp_count       (rsp_count)
   );

endmodule
`default_nettype wire

>>> bench/indexed_binary_min_heap_tb.sv
// self-checking bench for the indexed binary min-heap: driven request queue, predicted responses
`default_nettype none
module indexed_binary_min_heap_tb;
   import ibmh_pkg::*;

   typedef struct packed {
      logic [1:0]          action;
      logic [KEY_BITS-1:0] key;
      logic [ELEM_W-1:0]   element;
   } heap_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [KEY_BITS-1:0] out_key;
      logic [ELEM_W-1:0]   out_element;
      logic                is_present;
      logic [IDX_W-1:0]    position;
      logic [CNT_W-1:0]    count;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = ACT_INSERT;
   logic [KEY_BITS-1:0] req_key = '0;
   logic [ELEM_W-1:0] req_element = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [KEY_BITS-1:0] rsp_out_key;
   logic [ELEM_W-1:0] rsp_out_element;
   logic rsp_is_present;
   logic [IDX_W-1:0] rsp_position;
   logic [CNT_W-1:0] rsp_count;

   indexed_binary_min_heap u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_key(req_key), .req_element(req_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key), .rsp_out_element(rsp_out_element),
      .rsp_is_present(rsp_is_present), .rsp_position(rsp_position),
      .rsp_count(rsp_count)
   );

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit stim_done = 0;

   // predictor state
   logic [KEY_BITS-1:0] m_key[HEAP_DEPTH];
   logic [ELEM_W-1:0]   m_elem[HEAP_DEPTH];
   logic [IDX_W-1:0]    m_slot[ELEMENT_IDS];
   bit                  m_present[ELEMENT_IDS];
   int                  m_count = 0;
   bit                  used_ids[ELEMENT_IDS];

   initial forever #1 clock = ~clock;

   function automatic void heap_place(int slot, logic [KEY_BITS-1:0] k, logic [ELEM_W-1:0] e);
      m_key[slot] = k;
      m_elem[slot] = e;
      m_slot[e] = slot[IDX_W-1:0];
   endfunction

   function automatic void heap_swap(int a, int b);
      logic [KEY_BITS-1:0] k;
      logic [ELEM_W-1:0] e;
      k = m_key[a];
      e = m_elem[a];
      heap_place(a, m_key[b], m_elem[b]);
      heap_place(b, k, e);
   endfunction

   function automatic heap_rsp_type heap_predict(heap_req_type r);
      heap_rsp_type o;
      int i, p, l, rt, best;
      o = '0;
      if (r.action == ACT_INSERT) begin
         o.out_key = r.key;
         o.out_element = r.element;
         if (m_present[r.element]) o.status = STS_DUP;
         else if (m_count >= HEAP_DEPTH) o.status = STS_FULL;
         else begin
            i = m_count;
            m_count++;
            m_present[r.element] = 1;
            heap_place(i, r.key, r.element);
            while (i > 0) begin
               p = (i - 1) / 2;
               if (!(m_key[i] < m_key[p])) break;
               heap_swap(i, p);
               i = p;
            end
         end
      end else if (r.action == ACT_EXTRACT || r.action == ACT_PEEK) begin
         if (m_count == 0) o.status = STS_EMPTY;
         else begin
            o.out_key = m_key[0];
            o.out_element = m_elem[0];
            if (r.action == ACT_EXTRACT) begin
               m_present[m_elem[0]] = 0;
               m_count--;
               if (m_count > 0) begin
                  heap_place(0, m_key[m_count], m_elem[m_count]);
                  i = 0;
                  forever begin
                     l = 2 * i + 1;
                     rt = 2 * i + 2;
                     if (l >= m_count) break;
                     if (rt >= m_count) best = l;
                     else best = (m_key[l] < m_key[rt]) ? l : rt;
                     if (!(m_key[best] < m_key[i])) break;
                     heap_swap(i, best);
                     i = best;
                  end
               end
            end
         end
      end else if (m_present[r.element]) begin
         o.is_present = 1;
         o.position = m_slot[r.element];
      end
      o.count = m_count[CNT_W-1:0];
      return o;
   endfunction

   function automatic void add_req(logic [1:0] a, logic [KEY_BITS-1:0] k, logic [ELEM_W-1:0] e);
      heap_req_type r;
      r.action = a;
      r.key = k;
      r.element = e;
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic logic [KEY_BITS-1:0] rand_key();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            heap_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_action <= r.action;
            req_key <= r.key;
            req_element <= r.element;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on each accepted request beat
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         heap_req_type r;
         r.action = req_action;
         r.key = req_key;
         r.element = req_element;
         expected_rsps = {expected_rsps, heap_predict(r)};
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         heap_rsp_type got, exp_rsp;
         got = {rsp_status, rsp_out_key, rsp_out_element, rsp_is_present, rsp_position,
                rsp_count};
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %h", got);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (got.status !== exp_rsp.status || got.out_key !== exp_rsp.out_key ||
                got.out_element !== exp_rsp.out_element ||
                got.is_present !== exp_rsp.is_present ||
                got.position !== exp_rsp.position || got.count !== exp_rsp.count) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp sts %0d key %h elem %0d pres %0d pos %0d cnt %0d,",
                     exp_rsp.status, exp_rsp.out_key, exp_rsp.out_element,
                     exp_rsp.is_present, exp_rsp.position, exp_rsp.count,
                     " got sts %0d key %h elem %0d pres %0d pos %0d cnt %0d",
                     got.status, got.out_key, got.out_element, got.is_present,
                     got.position, got.count);
            end
         end
      end
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int n, a, e, ph;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_req(ACT_EXTRACT, '0, '0);
      add_req(ACT_PEEK, '0, '0);
      add_req(ACT_QUERY, '0, 10'h3ff);
      add_req(ACT_INSERT, '1, 10'h3ff);
      add_req(ACT_INSERT, 32'h5, 10'h000);
      add_req(ACT_INSERT, 32'h5, 10'h000);
      add_req(ACT_INSERT, '0, 10'h155);
      add_req(ACT_INSERT, 32'h5, 10'h2aa);
      add_req(ACT_INSERT, 32'h5, 10'h001);
      add_req(ACT_QUERY, '0, 10'h3ff);
      add_req(ACT_QUERY, '0, 10'h155);
      add_req(ACT_QUERY, '0, 10'h200);
      add_req(ACT_PEEK, '0, '0);
      for (int i = 0; i < 6; i++) add_req(ACT_EXTRACT, '0, '0);
      add_req(ACT_QUERY, '0, 10'h000);
      wait_drained();

      // random phases
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         for (n = 0; n < 190; n++) begin
            a = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) e = $urandom_range(0, 1023);
            else e = $urandom_range(0, 63);
            if (a < 45) add_req(ACT_INSERT, rand_key(), e[ELEM_W-1:0]);
            else if (a < 75) add_req(ACT_EXTRACT, $urandom, ELEM_W'($urandom));
            else if (a < 85) add_req(ACT_PEEK, $urandom, ELEM_W'($urandom));
            else add_req(ACT_QUERY, $urandom, e[ELEM_W-1:0]);
         end
         wait_drained();
      end
      repeat (30) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
